// File: src/ppfa_pkg.sv
// ppfa_pkg: shared widths, register reset values, register indexes and sequencer states
// for the periodic pair force accumulator; no dependencies
package ppfa_pkg;

  localparam int PosW           = 24;
  localparam int ForceW         = 32;
  localparam int CfgAddrW       = 3;
  localparam int DefPosFracBits = 16;

  // squared distance, root and remainder of the shared compare-subtract unit
  localparam int SqW     = 50;
  localparam int SqSteps = SqW / 2;
  localparam int RootW   = 25;
  localparam int RemW    = 28;

  // shared multiplier operands and product
  localparam int MulAW = 24;
  localparam int MulBW = 32;
  localparam int MulPW = MulAW + MulBW;

  localparam logic [PosW-1:0] BoxReset = 24'd1237299;
  localparam logic [PosW-1:0] EqReset  = 24'd54613;
  localparam logic [PosW-1:0] CutReset = 24'd65536;
  localparam logic [PosW-1:0] RepReset = 24'd2359296;
  localparam logic [PosW-1:0] AdhReset = 24'd294912;
  localparam logic [PosW-1:0] MobReset = 24'd65536;

  typedef enum logic [CfgAddrW-1:0] {
    REG_BOX = 3'd0,
    REG_EQ  = 3'd1,
    REG_CUT = 3'd2,
    REG_REP = 3'd3,
    REG_ADH = 3'd4,
    REG_MOB = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_REGION,
    ST_MGAIN,
    ST_PLO,
    ST_PHI,
    ST_DIV,
    ST_ACC,
    ST_OUTX,
    ST_OUTY
  } state_t;

endpackage

// File: src/ppfa_if.sv
// ppfa_in_if / ppfa_out_if: valid-ready channels for pair items and force results
// depends on ppfa_pkg for field widths
interface ppfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppfa_pkg::PosW-1:0]     self_x;
  logic [ppfa_pkg::PosW-1:0]     self_y;
  logic [ppfa_pkg::PosW-1:0]     other_x;
  logic [ppfa_pkg::PosW-1:0]     other_y;
  logic                          last_pair;

  modport source(output valid, self_x, self_y, other_x, other_y, last_pair, input ready);
  modport sink(input valid, self_x, self_y, other_x, other_y, last_pair, output ready);
endinterface

interface ppfa_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ppfa_pkg::ForceW-1:0] force_x;
  logic signed [ppfa_pkg::ForceW-1:0] force_y;
  logic                               coincident_seen;

  modport source(output valid, force_x, force_y, coincident_seen, input ready);
  modport sink(input valid, force_x, force_y, coincident_seen, output ready);
endinterface

// File: src/ppfa_wrap.sv
// ppfa_wrap: separation of two coordinates wrapped once to the nearest periodic image
// gives magnitude and sign; depends on ppfa_pkg
module ppfa_wrap (
  input  logic [ppfa_pkg::PosW-1:0] a,
  input  logic [ppfa_pkg::PosW-1:0] b,
  input  logic [ppfa_pkg::PosW-1:0] box,
  output logic [ppfa_pkg::PosW-1:0] mag,
  output logic                      neg
);

  logic [ppfa_pkg::PosW:0]   dv;
  logic [ppfa_pkg::PosW-1:0] raw_mag;
  logic                      raw_neg;
  logic                      wrap;
  logic                      below_box;

  always_comb begin
    dv        = {1'b0, a} - {1'b0, b};
    raw_neg   = dv[ppfa_pkg::PosW];
    raw_mag   = raw_neg ? ppfa_pkg::PosW'(-dv) : dv[ppfa_pkg::PosW-1:0];
    wrap      = {raw_mag, 1'b0} > {1'b0, box};
    below_box = raw_mag < box;
    if (wrap) begin
      mag = below_box ? (box - raw_mag) : (raw_mag - box);
      neg = raw_neg ^ below_box;
    end else begin
      mag = raw_mag;
      neg = raw_neg;
    end
  end

endmodule

// File: src/ppfa_cmpsub.sv
// ppfa_cmpsub: shared compare-subtract step for the square root and the divider
// depends on ppfa_pkg
module ppfa_cmpsub (
  input  logic [ppfa_pkg::RemW-1:0] a,
  input  logic [ppfa_pkg::RemW-1:0] b,
  output logic                      ge,
  output logic [ppfa_pkg::RemW-1:0] diff
);

  logic [ppfa_pkg::RemW:0] d;

  assign d    = {1'b0, a} - {1'b0, b};
  assign ge   = ~d[ppfa_pkg::RemW];
  assign diff = d[ppfa_pkg::RemW-1:0];

endmodule

// File: src/periodic_pair_force_accumulator.sv
// periodic_pair_force_accumulator: top level, sequencer around one shared multiplier
// and one shared compare-subtract unit; depends on ppfa_pkg, ppfa_if, ppfa_wrap, ppfa_cmpsub

// Accumulates the soft-sphere force on one particle from a run of neighbour
// transactions. Each input transaction carries the particle and one neighbour
// position; the separation is wrapped once into the periodic box, its length is
// found by a bit-serial square root, a linear repulsion (inside eq_radius) or
// adhesion (up to cutoff_radius) is projected onto the unit separation by a
// bit-serial divide, and added to saturating x and y sums. The transaction with
// last_pair set produces one result: both sums scaled by mobility, plus a flag
// telling whether some pair in the run had zero distance (that pair is skipped).
// One transaction is worked at a time and in_ch.ready is low meanwhile. The
// divide gives one quotient bit per cycle, over 72 - POS_FRAC_BITS numerator
// bits, for each of x and y, and the root, like the divide, runs bit-serially
// on the one compare-subtract unit. A pair at zero distance skips the root and
// the divide, and a pair beyond the cut-off skips the divide. A last pair then
// goes through the mobility scaling of x and y; the result sits in an output
// register, so the next run starts while it waits, unless a second result is due.
// Configuration writes belong between runs, while no transaction is in flight.
module periodic_pair_force_accumulator #(
  parameter int POS_FRAC_BITS = ppfa_pkg::DefPosFracBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ppfa_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [ppfa_pkg::PosW-1:0]     cfg_wdata,
  ppfa_in_if.sink                       in_ch,
  ppfa_out_if.source                    out_ch
);

  // numerator of the projection divide, and iteration counter
  localparam int NumW    = 72 - POS_FRAC_BITS;
  localparam int IterMax = (NumW > ppfa_pkg::SqSteps) ? NumW : ppfa_pkg::SqSteps;
  localparam int CntW    = $clog2(IterMax);
  localparam int AccW    = NumW + 2;
  localparam int PosW    = ppfa_pkg::PosW;
  localparam int ForceW  = ppfa_pkg::ForceW;
  localparam int RemW    = ppfa_pkg::RemW;
  localparam int RootW   = ppfa_pkg::RootW;
  localparam int SqW     = ppfa_pkg::SqW;
  localparam int MulPW   = ppfa_pkg::MulPW;

  localparam logic [MulPW-1:0] RoundHalf = MulPW'(1) << (POS_FRAC_BITS - 1);

  // configuration registers
  logic [PosW-1:0] box_r, eq_r, cut_r, rep_r, adh_r, mob_r;

  // sequencer
  ppfa_pkg::state_t state_r, state_nxt;
  logic [CntW-1:0]  cnt_r;

  // per-pair working registers
  logic [PosW-1:0]  ax_r, ay_r;
  logic             negx_r, negy_r;
  logic             last_r;
  logic [SqW-1:0]   s_r;
  logic [RootW-1:0] root_r;
  logic [RemW-1:0]  rem_r;
  logic             repel_r;
  logic [PosW-1:0]  diff_r;
  logic [47:0]      m_r;
  logic [NumW-1:0]  num_r;
  logic [NumW-1:0]  q_r;
  logic             lane_r;

  // run state
  logic signed [ForceW-1:0] sum_x_r, sum_y_r;
  logic                     flag_r;

  // result staging and output register
  logic signed [ForceW-1:0] fx_r;
  logic signed [ForceW-1:0] out_fx_r, out_fy_r;
  logic                     out_coin_r;
  logic                     out_valid_r;

  // wrapped separations
  logic [PosW-1:0] wx_mag, wy_mag;
  logic            wx_neg, wy_neg;

  // shared multiplier
  logic [ppfa_pkg::MulAW-1:0] mul_a;
  logic [ppfa_pkg::MulBW-1:0] mul_b;
  logic [MulPW-1:0]           mul_p;

  // shared compare-subtract unit
  logic [RemW-1:0] cs_a, cs_b, cs_diff;
  logic            cs_ge;

  // combinational helpers
  logic                     in_take;
  logic                     out_free;
  logic [SqW-1:0]           s_sum;
  logic                     near_eq, near_cut;
  logic [PosW-1:0]          mag_cur;
  logic                     neg_cur;
  logic [72:0]              num_sum;
  logic signed [AccW-1:0]   acc_t;
  logic signed [ForceW-1:0] acc_sat;
  logic signed [ForceW-1:0] sum_cur;
  logic signed [ForceW-1:0] scaled;

  ppfa_wrap u_wrap_x (
    .a   (in_ch.self_x),
    .b   (in_ch.other_x),
    .box (box_r),
    .mag (wx_mag),
    .neg (wx_neg)
  );

  ppfa_wrap u_wrap_y (
    .a   (in_ch.self_y),
    .b   (in_ch.other_y),
    .box (box_r),
    .mag (wy_mag),
    .neg (wy_neg)
  );

  ppfa_cmpsub u_cmpsub (
    .a    (cs_a),
    .b    (cs_b),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  // rounds mobility*|sum| and restores the sign, saturating to 32 bits
  function automatic logic signed [ForceW-1:0] scale_sat(input logic [MulPW-1:0] p,
                                                         input logic neg);
    logic [MulPW-1:0] r;
    begin
      r = (p + RoundHalf) >> POS_FRAC_BITS;
      if (neg) begin
        if (r > (MulPW'(1) << (ForceW - 1))) begin
          scale_sat = {1'b1, {(ForceW-1){1'b0}}};
        end else begin
          scale_sat = ForceW'(-r);
        end
      end else begin
        if (r > MulPW'({1'b0, {(ForceW-1){1'b1}}})) begin
          scale_sat = {1'b0, {(ForceW-1){1'b1}}};
        end else begin
          scale_sat = ForceW'(r);
        end
      end
    end
  endfunction

  assign mul_p    = MulPW'(mul_a) * MulPW'(mul_b);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign mag_cur  = lane_r ? ay_r : ax_r;
  assign neg_cur  = lane_r ? negy_r : negx_r;
  assign sum_cur  = lane_r ? sum_y_r : sum_x_r;

  // multiplier and compare-subtract operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    cs_a  = '0;
    cs_b  = '0;
    unique case (state_r)
      ppfa_pkg::ST_SQX: begin
        mul_a = ax_r;
        mul_b = 32'(ax_r);
      end
      ppfa_pkg::ST_SQY: begin
        mul_a = ay_r;
        mul_b = 32'(ay_r);
      end
      ppfa_pkg::ST_SQRT: begin
        // bring down two bits of s, trial divisor is 4*root + 1
        cs_a = {rem_r[RemW-3:0], s_r[SqW-1:SqW-2]};
        cs_b = {1'b0, root_r, 2'b01};
      end
      ppfa_pkg::ST_MGAIN: begin
        mul_a = repel_r ? rep_r : adh_r;
        mul_b = 32'(diff_r);
      end
      ppfa_pkg::ST_PLO: begin
        mul_a = mag_cur;
        mul_b = m_r[31:0];
      end
      ppfa_pkg::ST_PHI: begin
        mul_a = mag_cur;
        mul_b = 32'(m_r[47:32]);
      end
      ppfa_pkg::ST_DIV: begin
        cs_a = {1'b0, rem_r[RemW-3:0], num_r[NumW-1]};
        cs_b = RemW'(root_r);
      end
      ppfa_pkg::ST_OUTX: begin
        mul_a = mob_r;
        mul_b = sum_x_r[ForceW-1] ? 32'(-sum_x_r) : 32'(sum_x_r);
      end
      ppfa_pkg::ST_OUTY: begin
        mul_a = mob_r;
        mul_b = sum_y_r[ForceW-1] ? 32'(-sum_y_r) : 32'(sum_y_r);
      end
      default: begin
      end
    endcase
  end

  // arithmetic around the shared units
  always_comb begin
    s_sum    = s_r + SqW'(mul_p);
    near_eq  = root_r < RootW'(eq_r);
    near_cut = root_r < RootW'(cut_r);
    num_sum  = 73'(num_r) + (73'(mul_p) << 32) + 73'(root_r[RootW-1:1]);
    // repulsion pushes along the separation, adhesion pulls against it
    if (neg_cur ^ !repel_r) begin
      acc_t = AccW'(sum_cur) - $signed({2'b00, q_r});
    end else begin
      acc_t = AccW'(sum_cur) + $signed({2'b00, q_r});
    end
    if (acc_t > $signed(AccW'({1'b0, {(ForceW-1){1'b1}}}))) begin
      acc_sat = {1'b0, {(ForceW-1){1'b1}}};
    end else if (acc_t < -$signed(AccW'({1'b1, {(ForceW-1){1'b0}}}))) begin
      acc_sat = {1'b1, {(ForceW-1){1'b0}}};
    end else begin
      acc_sat = ForceW'(acc_t);
    end
    scaled = scale_sat(mul_p, lane_r ? sum_y_r[ForceW-1] : sum_x_r[ForceW-1]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppfa_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ppfa_pkg::ST_SQX;
        end
      end
      ppfa_pkg::ST_SQX: begin
        state_nxt = ppfa_pkg::ST_SQY;
      end
      ppfa_pkg::ST_SQY: begin
        if (s_sum == '0) begin
          state_nxt = last_r ? ppfa_pkg::ST_OUTX : ppfa_pkg::ST_IDLE;
        end else begin
          state_nxt = ppfa_pkg::ST_SQRT;
        end
      end
      ppfa_pkg::ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = ppfa_pkg::ST_REGION;
        end
      end
      ppfa_pkg::ST_REGION: begin
        if (near_eq || near_cut) begin
          state_nxt = ppfa_pkg::ST_MGAIN;
        end else begin
          state_nxt = last_r ? ppfa_pkg::ST_OUTX : ppfa_pkg::ST_IDLE;
        end
      end
      ppfa_pkg::ST_MGAIN: begin
        state_nxt = ppfa_pkg::ST_PLO;
      end
      ppfa_pkg::ST_PLO: begin
        state_nxt = ppfa_pkg::ST_PHI;
      end
      ppfa_pkg::ST_PHI: begin
        state_nxt = ppfa_pkg::ST_DIV;
      end
      ppfa_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ppfa_pkg::ST_ACC;
        end
      end
      ppfa_pkg::ST_ACC: begin
        if (!lane_r) begin
          state_nxt = ppfa_pkg::ST_PLO;
        end else begin
          state_nxt = last_r ? ppfa_pkg::ST_OUTX : ppfa_pkg::ST_IDLE;
        end
      end
      ppfa_pkg::ST_OUTX: begin
        state_nxt = ppfa_pkg::ST_OUTY;
      end
      ppfa_pkg::ST_OUTY: begin
        // hold until the previous result has left the output register
        if (out_free) begin
          state_nxt = ppfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppfa_pkg::ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready            = (state_r == ppfa_pkg::ST_IDLE);
    out_ch.valid           = out_valid_r;
    out_ch.force_x         = out_fx_r;
    out_ch.force_y         = out_fy_r;
    out_ch.coincident_seen = out_coin_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= ppfa_pkg::BoxReset;
      eq_r  <= ppfa_pkg::EqReset;
      cut_r <= ppfa_pkg::CutReset;
      rep_r <= ppfa_pkg::RepReset;
      adh_r <= ppfa_pkg::AdhReset;
      mob_r <= ppfa_pkg::MobReset;
    end else if (cfg_we) begin
      unique case (ppfa_pkg::cfg_reg_t'(cfg_addr))
        ppfa_pkg::REG_BOX: box_r <= cfg_wdata;
        ppfa_pkg::REG_EQ:  eq_r  <= cfg_wdata;
        ppfa_pkg::REG_CUT: cut_r <= cfg_wdata;
        ppfa_pkg::REG_REP: rep_r <= cfg_wdata;
        ppfa_pkg::REG_ADH: adh_r <= cfg_wdata;
        ppfa_pkg::REG_MOB: mob_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppfa_pkg::ST_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new result may replace the one leaving in the same cycle
      if (state_r == ppfa_pkg::ST_OUTY && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ppfa_pkg::ST_SQY: begin
          if (s_sum == '0) begin
            flag_r <= 1'b1;
          end
        end
        ppfa_pkg::ST_ACC: begin
          if (lane_r) begin
            sum_y_r <= acc_sat;
          end else begin
            sum_x_r <= acc_sat;
          end
        end
        ppfa_pkg::ST_OUTY: begin
          if (out_free) begin
            sum_x_r <= '0;
            sum_y_r <= '0;
            flag_r  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      ax_r   <= wx_mag;
      ay_r   <= wy_mag;
      negx_r <= wx_neg;
      negy_r <= wy_neg;
      last_r <= in_ch.last_pair;
    end
    case (state_r)
      ppfa_pkg::ST_SQX: begin
        s_r <= SqW'(mul_p);
      end
      ppfa_pkg::ST_SQY: begin
        // x lane is scaled first in the output sequence
        s_r    <= s_sum;
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= CntW'(ppfa_pkg::SqSteps - 1);
        lane_r <= 1'b0;
      end
      ppfa_pkg::ST_SQRT: begin
        s_r   <= s_r << 2;
        cnt_r <= cnt_r - 1'b1;
        if (cs_ge) begin
          rem_r  <= cs_diff;
          root_r <= {root_r[RootW-2:0], 1'b1};
        end else begin
          rem_r  <= cs_a;
          root_r <= {root_r[RootW-2:0], 1'b0};
        end
      end
      ppfa_pkg::ST_REGION: begin
        // floor(sqrt(s)) < r exactly when s < r*r
        repel_r  <= near_eq;
        diff_r   <= near_eq ? PosW'(RootW'(eq_r) - root_r) : PosW'(root_r - RootW'(eq_r));
        lane_r   <= 1'b0;
      end
      ppfa_pkg::ST_MGAIN: begin
        m_r <= 48'((mul_p + RoundHalf) >> POS_FRAC_BITS);
      end
      ppfa_pkg::ST_PLO: begin
        num_r <= NumW'(mul_p);
      end
      ppfa_pkg::ST_PHI: begin
        // add the high partial product and half the divisor for rounding
        num_r <= NumW'(num_sum);
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= CntW'(NumW - 1);
      end
      ppfa_pkg::ST_DIV: begin
        num_r <= num_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cs_ge) begin
          rem_r <= cs_diff;
          q_r   <= {q_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= cs_a;
          q_r   <= {q_r[NumW-2:0], 1'b0};
        end
      end
      ppfa_pkg::ST_ACC: begin
        // y lane next, or back to x once both lanes are summed
        lane_r <= !lane_r;
      end
      ppfa_pkg::ST_OUTX: begin
        fx_r   <= scaled;
        lane_r <= 1'b1;
      end
      ppfa_pkg::ST_OUTY: begin
        if (out_free) begin
          out_fx_r   <= fx_r;
          out_fy_r   <= scaled;
          out_coin_r <= flag_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
